>>> hdl/xorshift_fisher_yates_shuffler_unit_macros.svh
// assertion macros for the shuffler unit
`ifndef XORSHIFT_FISHER_YATES_SHUFFLER_UNIT_MACROS_SVH
`define XORSHIFT_FISHER_YATES_SHUFFLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define XFYS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define XFYS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/xfys_pkg.sv
// shared types, constants and the generator step of the shuffler unit
`timescale 1ns / 1ps
`default_nettype none

package xfys_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int ITEM_BITS_DEF = 16;
    localparam int GEN_BITS      = 32;

    localparam logic [GEN_BITS-1:0] SEED_RESET      = 32'h00C0_FFEE;
    localparam logic [GEN_BITS-1:0] ZERO_STATE_FILL = 32'hDEAD_BEEF;

    localparam int XS_SHIFT_A = 13;
    localparam int XS_SHIFT_B = 17;
    localparam int XS_SHIFT_C = 5;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DRAW,
        ST_DIV,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // one xorshift32 step, zero state replaced first
    function automatic logic [GEN_BITS-1:0] xs32_step(input logic [GEN_BITS-1:0] s);
        logic [GEN_BITS-1:0] x;
        x = (s == '0) ? ZERO_STATE_FILL : s;
        x = x ^ (x << XS_SHIFT_A);
        x = x ^ (x >> XS_SHIFT_B);
        x = x ^ (x << XS_SHIFT_C);
        return x;
    endfunction

endpackage

`default_nettype wire

>>> hdl/xorshift_fisher_yates_shuffler_unit.sv
// top level of the xorshift32 driven fisher-yates shuffler unit
`timescale 1ns / 1ps
`default_nettype none

// Random permutation engine. Items arrive on the slave stream and are queued
// into an internal store of CAPACITY entries, one item per cycle; items beyond
// capacity are dropped without notice. The item flagged with tlast is queued
// too and closes the batch: the block then stops taking items, shuffles the
// store with a fisher-yates pass (for i from count-1 down to 1, j = draw mod
// (i+1), swap entries i and j) and sends every item out on the master stream
// in store order, tlast on the final one. Each swap takes the xorshift32 draw,
// the bit-serial remainder unit (32 iterations plus the done flag), and the
// store (two registered reads, two writes). Emission reads each item from the
// store, waits while the master side stalls, then loads the output register.
// The generator state persists across batches; a write on the cfg channel
// reloads it with the seed (zero loads 0xC0FFEE instead). Seed writes are meant
// for idle time only.
module xorshift_fisher_yates_shuffler_unit
    import xfys_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int ITEM_BITS = ITEM_BITS_DEF,
    localparam int DATA_BITS = ((ITEM_BITS + 7) / 8) * 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // seed write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [GEN_BITS-1:0]   i_cfg_data,
    // item stream in
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire [DATA_BITS-1:0]  i_s_axis_tdata,  // item_value, zero pad
    input  wire                  i_s_axis_tlast,  // batch_end
    // shuffled stream out
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    output logic [DATA_BITS-1:0] o_m_axis_tdata,  // out_value, zero pad
    output logic                 o_m_axis_tlast   // out_last
);

`include "xorshift_fisher_yates_shuffler_unit_macros.svh"

    localparam int IW = $clog2(CAPACITY);       // store index
    localparam int CW = $clog2(CAPACITY + 1);   // item count

    // sequencer and bookkeeping
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;    // items queued so far
    logic [CW-1:0]         r_n, n_n;            // batch size being worked on
    logic [IW-1:0]         r_i, n_i;            // fisher-yates upper index
    logic [IW-1:0]         r_j, n_j;            // drawn partner index
    logic [IW-1:0]         r_k, n_k;            // emission index
    logic [GEN_BITS-1:0]   r_gen, n_gen;        // xorshift32 state
    logic [ITEM_BITS-1:0]  r_vi, n_vi;          // entry i held during swap

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [ITEM_BITS-1:0]  r_out_value, n_out_value;
    logic                  r_out_last, n_out_last;

    // item store, one write and one registered read per cycle
    logic [ITEM_BITS-1:0]  r_mem [CAPACITY];
    logic [ITEM_BITS-1:0]  r_rdata;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [ITEM_BITS-1:0]  w_wdata;
    logic [IW-1:0]         w_raddr;

    // shared remainder unit
    logic                  w_div_start;
    t_div_status           w_div_status;
    logic [CW-1:0]         w_div_rem;
    logic [GEN_BITS-1:0]   w_draw;

    logic [CW-1:0]         w_count_inc;
    logic                  w_out_free;
    logic                  w_emit_last;

    assign w_draw      = xs32_step(r_gen);
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_emit_last = ((CW'(r_k) + CW'(1)) == r_n);
    assign w_count_inc = (r_count < CW'(CAPACITY)) ? (r_count + CW'(1)) : r_count;

    xfys_divider #(
        .DIVISOR_BITS (CW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_draw),
        .i_divisor   (CW'(r_i) + CW'(1)),
        .o_status    (w_div_status),
        .o_remainder (w_div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_gen       = r_gen;
        n_vi        = r_vi;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_waddr     = r_count[IW-1:0];
        w_wdata     = i_s_axis_tdata[ITEM_BITS-1:0];
        w_raddr     = r_i;
        w_div_start = 1'b0;
        o_s_axis_tready = 1'b0;

        // result taken downstream
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // seed write reloads the generator
        if (i_cfg_valid) begin
            n_gen = (i_cfg_data == '0) ? SEED_RESET : i_cfg_data;
        end

        case (r_state)
            ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    // append unless full
                    w_we = (r_count < CW'(CAPACITY));
                    if (i_s_axis_tlast) begin
                        n_count = '0;
                        n_n     = w_count_inc;
                        n_i     = IW'(w_count_inc - CW'(1));
                        n_k     = '0;
                        // single-item batch needs no draws
                        n_state = (w_count_inc == CW'(1)) ? ST_EMIT_RD : ST_DRAW;
                    end else begin
                        n_count = w_count_inc;
                    end
                end
            end
            ST_DRAW: begin
                n_gen       = w_draw;
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_status.done) begin
                    n_j     = w_div_rem[IW-1:0];
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                w_raddr = r_i;
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                n_vi    = r_rdata;
                w_raddr = r_j;
                n_state = ST_WR_I;
            end
            ST_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_rdata;
                n_state = ST_WR_J;
            end
            ST_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_vi;
                if (r_i == IW'(1)) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_i     = r_i - IW'(1);
                    n_state = ST_DRAW;
                end
            end
            ST_EMIT_RD: begin
                w_raddr = r_k;
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                // keep the read address so the data stays put while stalled
                w_raddr = r_k;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_rdata;
                    n_out_last  = w_emit_last;
                    if (w_emit_last) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_gen       <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_n         <= n_n;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
        r_vi        <= n_vi;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_BITS'(r_out_value);
    assign o_m_axis_tlast  = r_out_last;

    // checks on the sequencer
    `XFYS_ASSERT_NEXT(a_div_started, r_state == ST_DRAW, w_div_status.busy, "divider not started")
    `XFYS_ASSERT_NEXT(a_j_in_range, (r_state == ST_DIV) && w_div_status.done, r_j <= r_i, "j above i")
    `XFYS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "count beyond capacity")
    `XFYS_ASSERT_NOW(a_emit_index, r_state == ST_EMIT_LD, CW'(r_k) < r_n, "emit index beyond batch")

endmodule

`default_nettype wire

>>> hdl/xfys_divider.sv
// iterative restoring divider, one quotient bit per cycle, remainder only
`timescale 1ns / 1ps
`default_nettype none

module xfys_divider
    import xfys_pkg::*;
#(
    parameter int DIVISOR_BITS = 7
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [GEN_BITS-1:0]      i_dividend,
    input  wire [DIVISOR_BITS-1:0]  i_divisor,
    output t_div_status             o_status,
    output logic [DIVISOR_BITS-1:0] o_remainder
);

    localparam int CNT_BITS = $clog2(GEN_BITS);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [CNT_BITS-1:0]     r_cnt, n_cnt;
    logic [GEN_BITS-1:0]     r_dvd, n_dvd;
    logic [DIVISOR_BITS-1:0] r_div, n_div;
    logic [DIVISOR_BITS-1:0] r_rem, n_rem;
    logic [DIVISOR_BITS:0]   w_trial;

    assign w_trial = {r_rem, r_dvd[GEN_BITS-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // shift one dividend bit in, subtract when it fits
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = DIVISOR_BITS'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = w_trial[DIVISOR_BITS-1:0];
            end
            n_dvd = {r_dvd[GEN_BITS-2:0], 1'b0};
            n_cnt = r_cnt + CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(GEN_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_remainder   = r_rem;

endmodule

`default_nettype wire

>>> verif/xorshift_fisher_yates_shuffler_unit_tb.sv
// self-checking testbench for the xorshift32 fisher-yates shuffler unit
`timescale 1ns / 1ps

module xorshift_fisher_yates_shuffler_unit_tb;
    import xfys_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int ITEM_W      = ITEM_BITS_DEF;
    localparam int DATA_W      = ((ITEM_W + 7) / 8) * 8;
    // items offered over the whole run, directed tests included
    localparam int TOTAL_ITEMS = 380;
    // cycle limit for the watchdog that ends a hung run
    localparam int CYCLE_LIMIT = 600000;
    // cycles to let the unit fall back to loading after the final item
    localparam int SETTLE      = 60;
    localparam int IDLE_PCT    = 13;

    typedef struct {
        logic [ITEM_W-1:0] value;
        logic              last;
    } t_shuffled_item;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // seed write channel
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [GEN_BITS-1:0] i_cfg_data  = '0;

    // item stream into the unit
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata  = '0;  // item_value, zero pad
    logic              i_s_axis_tlast  = 1'b0; // batch_end

    // shuffled stream out of the unit
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;        // out_value, zero pad
    logic              o_m_axis_tlast;        // out_last

    // predictor state: a private copy of the store, count and generator
    logic [ITEM_W-1:0]   held_items [CAP];
    int unsigned         held_count = 0;
    logic [GEN_BITS-1:0] gen_state  = SEED_RESET;

    t_shuffled_item shuffled_q [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int items_sent   = 0;
    bit no_idle      = 1'b0;

    xorshift_fisher_yates_shuffler_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // free-running clock, 20 ns period
    always #10 i_clk = ~i_clk;

    // hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, shuffled_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        i_m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // one xorshift32 step on the predictor's generator copy
    function automatic logic [GEN_BITS-1:0] next_draw();
        logic [GEN_BITS-1:0] x;
        x = (gen_state == '0) ? ZERO_STATE_FILL : gen_state;
        x = x ^ (x << XS_SHIFT_A);
        x = x ^ (x >> XS_SHIFT_B);
        x = x ^ (x << XS_SHIFT_C);
        gen_state = x;
        return x;
    endfunction

    // fisher-yates pass over the held batch, then queue it in store order
    task automatic shuffle_batch();
        int unsigned       j;
        logic [ITEM_W-1:0] t;
        t_shuffled_item    e;
        // a single-item batch makes no draws
        for (int unsigned i = held_count - 1; i > 0 && i < CAP; i--) begin
            j = next_draw() % (i + 1);
            t = held_items[i];
            held_items[i] = held_items[j];
            held_items[j] = t;
        end
        for (int unsigned i = 0; i < held_count; i++) begin
            e.value = held_items[i];
            e.last  = (i + 1 == held_count);
            shuffled_q.push_back(e);
        end
        held_count = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    // monitor: checks each result item and tracks accepted items and seeds
    always @(posedge i_clk) begin
        t_shuffled_item e;
        if (i_rst_n) begin
            // results always belong to batches closed on earlier edges
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (shuffled_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(o_m_axis_tdata),
                                    32'd0);
                end else begin
                    e = shuffled_q.pop_front();
                    if (o_m_axis_tdata !== DATA_W'(e.value))
                        report_mismatch("out_value", 32'(o_m_axis_tdata), 32'(e.value));
                    if (o_m_axis_tlast !== e.last)
                        report_mismatch("out_last", 32'(o_m_axis_tlast), 32'(e.last));
                end
            end
            // seed write reloads the generator, zero maps to the reset seed
            if (i_cfg_valid && o_cfg_ready)
                gen_state = (i_cfg_data == '0) ? SEED_RESET : i_cfg_data;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                // beyond capacity the item is dropped, tlast still closes the batch
                if (held_count < CAP) begin
                    held_items[held_count] = i_s_axis_tdata[ITEM_W-1:0];
                    held_count++;
                end
                if (i_s_axis_tlast)
                    shuffle_batch();
            end
        end
    end

    // offer one item, entered and left on a falling edge
    task automatic send_item(input logic [ITEM_W-1:0] value, input logic last);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= DATA_W'(value);
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // batch of random handles, tlast on the final one
    task automatic send_batch(input int len);
        for (int k = 0; k < len; k++)
            send_item(ITEM_W'($urandom), k == len - 1);
    endtask

    // sender holds off until every result is out and the unit is loading again
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        @(negedge i_clk);
        while (shuffled_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // seed write, only ever called with the unit drained
    task automatic write_seed(input logic [GEN_BITS-1:0] seed);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // reset seed, extreme handles, single-item and tiny batches
    task automatic test_reset_seed();
        send_item('1, 1'b1);
        send_item('0, 1'b0);
        send_item('1, 1'b1);
        send_item(16'h8000, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h7FFE, 1'b1);
        wait_drained();
    endtask

    // seed extremes, zero seed falls back to the reset value
    task automatic test_seed_extremes();
        write_seed(32'h0000_0001);
        send_item(16'h1234, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hA5A5, 1'b1);
        wait_drained();
        write_seed(32'hFFFF_FFFF);
        send_batch(4);
        wait_drained();
        write_seed(32'h0000_0000);
        send_item(16'h5A5A, 1'b0);
        send_item(16'h00FF, 1'b0);
        send_item(16'hFF00, 1'b1);
        wait_drained();
    endtask

    // exactly full store, then an overfilled one whose tlast item is dropped
    task automatic test_store_full();
        write_seed($urandom);
        send_batch(CAP);
        wait_drained();
        send_batch(CAP + 6);
        wait_drained();
    endtask

    // a stretch with neither side idling
    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        for (int b = 0; b < 4; b++)
            send_batch($urandom_range(2, 20));
        wait_drained();
        no_idle = 1'b0;
    endtask

    // random batch lengths, mostly short, some at and past capacity
    task automatic test_random_batches();
        int len;
        int pick;
        while (items_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 7)
                len = $urandom_range(CAP - 4, CAP + 6);
            else if (pick < 20)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            send_batch(len);
            // now and then reseed between batches, sometimes at the extremes
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                pick = $urandom_range(0, 9);
                write_seed(pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF :
                           pick == 2 ? 32'h1 : $urandom);
            end
        end
        wait_drained();
    endtask

    initial begin
        // synchronous reset, released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        test_reset_seed();
        test_seed_extremes();
        test_store_full();
        test_no_idle_stretch();
        test_random_batches();

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> xorshift_fisher_yates_shuffler_unit.f
+incdir+hdl
hdl/xfys_pkg.sv
hdl/xfys_divider.sv
hdl/xorshift_fisher_yates_shuffler_unit.sv
verif/xorshift_fisher_yates_shuffler_unit_tb.sv
